// ===== rtl/core/teb_pkg.sv =====
`timescale 1ns / 1ps
package teb_pkg;

  // Sizes of the beam counter and the cosine table
  localparam int MAX_BEAMS       = 2048;
  localparam int COS_TABLE_DEPTH = 1024;
  localparam int IDX_W           = $clog2(MAX_BEAMS);
  localparam int TAB_W           = $clog2(COS_TABLE_DEPTH + 1);

  // Angle datapath widths: start (23b signed) plus index times step
  localparam int ANG_W  = IDX_W + 16 + 2;
  localparam int PROD_W = ANG_W + 27;

  // Fixed constants of the TTC math
  localparam logic [16:0] TTC_CEIL_MS  = 17'd100000;
  localparam logic [25:0] PHASE_MUL    = 26'd42722830;
  localparam longint      PI_Q30       = 64'd3373259426;
  localparam int          QUEUE_DEPTH  = 2;
  localparam int          QPTR_W       = $clog2(QUEUE_DEPTH);

  // Divider: 41-bit dividend, two quotient bits per cycle
  localparam int NUM_W     = 42;
  localparam int DIV_STEPS = NUM_W / 2;
  localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

  // Configuration register indexes
  localparam logic [1:0] CFG_ANGLE_START = 2'd0;
  localparam logic [1:0] CFG_ANGLE_STEP  = 2'd1;
  localparam logic [1:0] CFG_THRESHOLD   = 2'd2;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] speed_mm_s;
    logic        [15:0] range_mm;
    logic               last_beam;
  } teb_in_t;

  typedef struct packed {
    logic        brake;
    logic [16:0] min_ttc_ms;
    logic [15:0] min_distance_mm;
  } teb_out_t;

  typedef struct packed {
    logic signed [22:0] angle_start;
    logic        [15:0] angle_step;
    logic        [16:0] brake_threshold_ms;
  } teb_cfg_t;

  typedef enum logic [1:0] {
    OP_SPEED,
    OP_BEAM,
    OP_LAST
  } teb_op_e;

  typedef struct packed {
    teb_op_e          op;
    logic [15:0]      data;
    logic [IDX_W-1:0] idx;
  } teb_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ANGLE,
    ST_PHASE,
    ST_FOLD,
    ST_ROM,
    ST_PROJ,
    ST_DIV,
    ST_UPD
  } teb_state_e;

  typedef logic signed [15:0] cos_rom_t [COS_TABLE_DEPTH+1];

  // Signed quotient truncated toward zero, by shift and subtract
  function automatic longint div_trunc(longint n, longint d);
    longint unsigned a;
    longint unsigned b;
    longint unsigned q;
    longint unsigned r;
    logic            neg;
    a   = (n < 0) ? longint'(-n) : n;
    b   = (d < 0) ? longint'(-d) : d;
    neg = (n < 0) ^ (d < 0);
    q   = 0;
    r   = 0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= b) begin
        r    = r - b;
        q[i] = 1'b1;
      end
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  // cos(pi * i / depth) in Q1.15 via an integer Taylor series in Q30
  function automatic logic signed [15:0] cos_entry(int unsigned i);
    logic   neg;
    longint j;
    longint x;
    longint x2;
    longint term;
    longint sum;
    neg = 1'b0;
    j   = longint'(i);
    if (2 * j > COS_TABLE_DEPTH) begin
      j   = COS_TABLE_DEPTH - j;
      neg = 1'b1;
    end
    x    = div_trunc(j * PI_Q30, longint'(COS_TABLE_DEPTH));
    x2   = (x * x) >>> 30;
    term = 64'sd1 <<< 30;
    sum  = term;
    for (int k = 1; k <= 8; k++) begin
      term = -div_trunc(term * x2, 64'sd1 <<< 30);
      term = div_trunc(term, longint'(2 * k - 1) * longint'(2 * k));
      sum  = sum + term;
    end
    if (sum < 0) sum = 0;
    sum = (sum + (64'sd1 <<< 14)) >>> 15;
    if (sum > 32767) sum = 32767;
    return neg ? -16'(sum) : 16'(sum);
  endfunction

  function automatic cos_rom_t build_cos_rom();
    cos_rom_t rom;
    for (int i = 0; i <= COS_TABLE_DEPTH; i++) begin
      rom[i] = cos_entry(i);
    end
    return rom;
  endfunction

endpackage

// ===== rtl/core/ttc_emergency_brake_top.sv =====
`timescale 1ns / 1ps
// Channel   Handshake             Payload
// input     push / full           in_word_i  (teb_in_t)
// result    empty / pop           out_word_o (teb_out_t)
// config    cfg_valid_i/ready_o   cfg_index_i, cfg_data_i
//
// A speed word is retired by the back end from idle; a beam word passes the
// angle, phase, fold, cosine table, projection, radix-4 divider and update
// steps there. A two-word queue parts front and back.
// Reset clears the queue, speed, scan minimum and all-time minimum range.
// A last beam waits in the back end while the result register is unread.
module ttc_emergency_brake_top import teb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  teb_in_t     in_word_i,
  output logic        empty,
  input  logic        pop,
  output teb_out_t    out_word_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [22:0] cfg_data_i
);

  teb_cfg_t   cfg_q;
  logic       q_wr, q_rd, q_valid;
  teb_entry_t wr_entry, rd_entry;

  assign cfg_ready_o = 1'b1;

  // Write configuration registers, ignore unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.angle_start        <= -23'sd3294199;
      cfg_q.angle_step         <= 16'd4563;
      cfg_q.brake_threshold_ms <= 17'd400;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ANGLE_START: cfg_q.angle_start        <= cfg_data_i;
        CFG_ANGLE_STEP:  cfg_q.angle_step         <= cfg_data_i[15:0];
        CFG_THRESHOLD:   cfg_q.brake_threshold_ms <= cfg_data_i[16:0];
        default: begin
        end
      endcase
    end
  end

  teb_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .in_word_i (in_word_i),
    .q_full_i  (full),
    .q_wr_o    (q_wr),
    .q_entry_o (wr_entry)
  );

  teb_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (q_wr),
    .wr_entry_i (wr_entry),
    .rd_i       (q_rd),
    .valid_o    (q_valid),
    .full_o     (full),
    .rd_entry_o (rd_entry)
  );

  teb_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_valid_i  (q_valid),
    .q_entry_i  (rd_entry),
    .q_rd_o     (q_rd),
    .pop        (pop),
    .empty      (empty),
    .out_word_o (out_word_o)
  );

endmodule

// ===== rtl/core/teb_front.sv =====
`timescale 1ns / 1ps
module teb_front import teb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  input  teb_in_t    in_word_i,
  input  logic       q_full_i,
  output logic       q_wr_o,
  output teb_entry_t q_entry_o
);

  logic [IDX_W-1:0] beam_idx_q, beam_idx_d;
  logic             accept;

  assign accept = push && !q_full_i;

  // Classify the word and tag beams with their scan index
  always_comb begin
    q_entry_o.idx = beam_idx_q;
    if (!in_word_i.kind) begin
      q_entry_o.op   = OP_SPEED;
      q_entry_o.data = in_word_i.speed_mm_s;
    end else begin
      q_entry_o.op   = in_word_i.last_beam ? OP_LAST : OP_BEAM;
      q_entry_o.data = in_word_i.range_mm;
    end
  end

  assign q_wr_o = accept;

  // Advance the beam index, hold at the end, clear on the last beam
  always_comb begin
    beam_idx_d = beam_idx_q;
    if (accept && in_word_i.kind) begin
      if (in_word_i.last_beam) begin
        beam_idx_d = '0;
      end else if (beam_idx_q < IDX_W'(MAX_BEAMS - 1)) begin
        beam_idx_d = beam_idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beam_idx_q <= '0;
    end else begin
      beam_idx_q <= beam_idx_d;
    end
  end

endmodule

// ===== rtl/core/teb_queue.sv =====
`timescale 1ns / 1ps
module teb_queue import teb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_i,
  input  teb_entry_t wr_entry_i,
  input  logic       rd_i,
  output logic       valid_o,
  output logic       full_o,
  output teb_entry_t rd_entry_o
);

  teb_entry_t        mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;
  logic              do_wr, do_rd;

  assign valid_o    = (count_q != '0);
  assign full_o     = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign rd_entry_o = mem_q[rd_ptr_q];
  assign do_wr      = wr_i && !full_o;
  assign do_rd      = rd_i && valid_o;

  // Store the incoming word
  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_entry_i;
  end

  // Advance pointers and the fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (do_rd) rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      if (do_wr && !do_rd) count_q <= count_q + 1'b1;
      else if (do_rd && !do_wr) count_q <= count_q - 1'b1;
    end
  end

endmodule

// ===== rtl/core/teb_back.sv =====
`timescale 1ns / 1ps
module teb_back import teb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  teb_cfg_t   cfg_i,
  input  logic       q_valid_i,
  input  teb_entry_t q_entry_i,
  output logic       q_rd_o,
  input  logic       pop,
  output logic       empty,
  output teb_out_t   out_word_o
);

  localparam cos_rom_t COS_ROM = build_cos_rom();

  teb_state_e state_q, state_d;

  teb_entry_t               ent_q;
  logic signed [15:0]       speed_q;
  logic [16:0]              scan_min_q;
  logic [15:0]              least_q;
  logic signed [ANG_W-1:0]  ang_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [TAB_W-1:0]         tab_q;
  logic signed [15:0]       cos_q;
  logic signed [31:0]       proj_q;
  logic [NUM_W-1:0]         num_q;
  logic [31:0]              rem_q;
  logic [DCNT_W-1:0]        dcnt_q;
  logic                     out_valid_q;
  teb_out_t                 out_q;

  logic                     take;
  logic                     commit;
  logic                     is_last;
  logic [31:0]              phase;
  logic [32:0]              fold;
  logic [47:0]              scaled;
  logic [47:0]              tab_full;
  logic [NUM_W-1:0]         num_d;
  logic [31:0]              rem_d;
  logic [16:0]              ttc_sat;
  logic [16:0]              min_next;
  logic [15:0]              least_next;
  logic [40:0]              num_init;

  assign is_last = (ent_q.op == OP_LAST);
  assign empty   = !out_valid_q;
  assign out_word_o = out_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (q_valid_i && q_entry_i.op != OP_SPEED) state_d = ST_ANGLE;
      ST_ANGLE: state_d = ST_PHASE;
      ST_PHASE: state_d = ST_FOLD;
      ST_FOLD:  state_d = ST_ROM;
      ST_ROM:   state_d = ST_PROJ;
      ST_PROJ:  state_d = ST_DIV;
      ST_DIV:   if (dcnt_q == DCNT_W'(DIV_STEPS - 1)) state_d = ST_UPD;
      ST_UPD:   if (commit) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    take   = 1'b0;
    commit = 1'b0;
    case (state_q)
      ST_IDLE: take   = q_valid_i;
      ST_UPD:  commit = !is_last || !out_valid_q || pop;
      default: begin
        take   = 1'b0;
        commit = 1'b0;
      end
    endcase
  end
  assign q_rd_o = take;

  // Fold the phase to a half turn and scale it to a table index
  always_comb begin
    phase = prod_q[47:16];
    fold  = (phase > 32'h8000_0000) ? (33'h1_0000_0000 - {1'b0, phase}) : {1'b0, phase};
    scaled   = 48'(fold) * 48'(COS_TABLE_DEPTH) + 48'h4000_0000;
    tab_full = scaled >> 31;
  end

  // Two restoring divide steps per cycle
  always_comb begin
    logic [32:0] trial;
    logic        nb;
    num_d = num_q;
    rem_d = rem_q;
    for (int s = 0; s < 2; s++) begin
      nb    = num_d[NUM_W-1];
      trial = {rem_d, nb} - {2'b0, proj_q[30:0]};
      num_d = {num_d[NUM_W-2:0], 1'b0};
      if (!trial[32]) begin
        rem_d    = trial[31:0];
        num_d[0] = 1'b1;
      end else begin
        rem_d = {rem_d[30:0], nb};
      end
    end
  end

  // Scan minimum and all-time range minimum
  assign num_init = 41'(ent_q.data) * 41'd1000 * 41'd32768;
  always_comb begin
    ttc_sat    = (num_q > NUM_W'(TTC_CEIL_MS)) ? TTC_CEIL_MS : num_q[16:0];
    min_next   = (proj_q > 0 && ttc_sat < scan_min_q) ? ttc_sat : scan_min_q;
    least_next = (ent_q.data < least_q) ? ent_q.data : least_q;
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE:  if (take) ent_q <= q_entry_i;
      ST_ANGLE: ang_q  <= ANG_W'(ANG_W'(cfg_i.angle_start)
                          + $signed({1'b0, ANG_W'(ent_q.idx) * ANG_W'(cfg_i.angle_step)}));
      ST_PHASE: prod_q <= PROD_W'(ang_q) * $signed({1'b0, PHASE_MUL});
      ST_FOLD:  tab_q  <= (tab_full > 48'(COS_TABLE_DEPTH)) ? TAB_W'(COS_TABLE_DEPTH)
                                                            : tab_full[TAB_W-1:0];
      ST_ROM:   cos_q  <= COS_ROM[tab_q];
      ST_PROJ: begin
        proj_q <= speed_q * cos_q;
        num_q  <= {1'b0, num_init};
        rem_q  <= '0;
      end
      ST_DIV: begin
        num_q <= num_d;
        rem_q <= rem_d;
      end
      default: begin
      end
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      speed_q     <= '0;
      scan_min_q  <= TTC_CEIL_MS;
      least_q     <= 16'hFFFF;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (take && q_entry_i.op == OP_SPEED) speed_q <= q_entry_i.data;
      if (state_q == ST_PROJ) dcnt_q <= '0;
      else if (state_q == ST_DIV) dcnt_q <= dcnt_q + 1'b1;
      if (commit && is_last) out_valid_q <= 1'b1;
      else if (pop && out_valid_q) out_valid_q <= 1'b0;
      if (commit) begin
        least_q <= least_next;
        if (is_last) begin
          scan_min_q <= TTC_CEIL_MS;
        end else begin
          scan_min_q <= min_next;
        end
      end
    end
  end

  // Hold the result word
  always_ff @(posedge clk_i) begin
    if (commit && is_last) begin
      out_q.brake           <= (min_next < cfg_i.brake_threshold_ms) && (speed_q > 0);
      out_q.min_ttc_ms      <= min_next;
      out_q.min_distance_mm <= least_next;
    end
  end

endmodule

// ===== dv/tb_ttc_emergency_brake_top.sv =====
`timescale 1ns / 1ps
module tb_ttc_emergency_brake_top;
  import teb_pkg::*;

  localparam logic       KIND_SPEED = 1'b0;
  localparam logic       KIND_BEAM  = 1'b1;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int         SETTLE     = 80;
  localparam int         LIMIT      = 1500000;
  localparam int         RAND_WORDS = 1850;

  // Brake predictor and store of expected brake words
  class brake_scoreboard;
    logic signed [22:0] start_ang;
    logic        [15:0] step_ang;
    logic        [16:0] thresh_ms;
    logic signed [15:0] speed;
    int unsigned        beam_idx;
    int unsigned        scan_min;
    int unsigned        least_mm;
    int                 cosq [COS_TABLE_DEPTH+1];
    teb_out_t           want_q [$];
    int                 errors;

    function new();
      for (int i = 0; i <= COS_TABLE_DEPTH; i++) cosq[i] = q15_cos(i);
      start_ang = -23'sd3294199;
      step_ang  = 16'd4563;
      thresh_ms = 17'd400;
      speed     = '0;
      beam_idx  = 0;
      scan_min  = 100000;
      least_mm  = 65535;
      errors    = 0;
    endfunction

    // cos(pi*i/depth) in Q1.15 from a Q30 power series
    function int q15_cos(int i);
      bit     flip;
      longint j, x, x2, term, acc;
      flip = 0;
      j    = i;
      if (2 * j > COS_TABLE_DEPTH) begin
        j    = COS_TABLE_DEPTH - j;
        flip = 1;
      end
      x    = (j * 64'sd3373259426) / COS_TABLE_DEPTH;
      x2   = (x * x) >>> 30;
      term = 64'sd1 <<< 30;
      acc  = term;
      for (int k = 1; k <= 8; k++) begin
        term = -(term * x2) / (64'sd1 <<< 30);
        term = term / (longint'(2 * k - 1) * longint'(2 * k));
        acc  = acc + term;
      end
      if (acc < 0) acc = 0;
      acc = (acc + (64'sd1 <<< 14)) / (64'sd1 <<< 15);
      if (acc > 32767) acc = 32767;
      return flip ? -int'(acc) : int'(acc);
    endfunction

    function void write_reg(logic [1:0] idx, logic [22:0] data);
      case (idx)
        CFG_ANGLE_START: start_ang = data;
        CFG_ANGLE_STEP:  step_ang  = data[15:0];
        CFG_THRESHOLD:   thresh_ms = data[16:0];
        default: ;
      endcase
    endfunction

    // Advance the predictor by one accepted input word
    function void note_input(teb_in_t w);
      longint          ang, proj;
      longint unsigned prod, p, t, num, ttc;
      logic [31:0]     phase;
      teb_out_t        r;
      if (w.kind == KIND_SPEED) begin
        speed = w.speed_mm_s;
        return;
      end
      ang   = longint'(start_ang) + longint'(beam_idx) * longint'(step_ang);
      prod  = longint'(ang) * 64'd42722830;
      phase = prod[47:16];
      p     = phase;
      if (p > 64'h8000_0000) p = 64'h1_0000_0000 - p;
      t = (p * COS_TABLE_DEPTH + 64'h4000_0000) >> 31;
      if (t > COS_TABLE_DEPTH) t = COS_TABLE_DEPTH;
      proj = longint'(speed) * longint'(cosq[t]);
      if (proj > 0) begin
        num = longint'(w.range_mm) * 1000 * 32768;
        ttc = num / proj;
        if (ttc > 100000) ttc = 100000;
        if (ttc < scan_min) scan_min = 32'(ttc);
      end
      if (w.range_mm < least_mm) least_mm = w.range_mm;
      if (!w.last_beam) begin
        if (beam_idx < MAX_BEAMS - 1) beam_idx++;
        return;
      end
      r.brake           = (scan_min < thresh_ms) && (speed > 0);
      r.min_ttc_ms      = 17'(scan_min);
      r.min_distance_mm = 16'(least_mm);
      want_q.push_back(r);
      scan_min = 100000;
      beam_idx = 0;
    endfunction

    // Compare one popped word with the oldest expectation
    function void check_result(teb_out_t got);
      teb_out_t w;
      if (want_q.size() == 0) begin
        $display("%0t: unexpected word %h", $time, got);
        errors++;
        return;
      end
      w = want_q.pop_front();
      if (got.brake !== w.brake) begin
        $display("%0t: brake exp %0d got %0d", $time, w.brake, got.brake);
        errors++;
      end
      if (got.min_ttc_ms !== w.min_ttc_ms) begin
        $display("%0t: min_ttc_ms exp %0d got %0d", $time, w.min_ttc_ms, got.min_ttc_ms);
        errors++;
      end
      if (got.min_distance_mm !== w.min_distance_mm) begin
        $display("%0t: min_distance_mm exp %0d got %0d", $time,
                 w.min_distance_mm, got.min_distance_mm);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        push, full, empty, pop;
  teb_in_t     in_word_i;
  teb_out_t    out_word_o;
  logic        cfg_valid_i, cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [22:0] cfg_data_i;

  brake_scoreboard sb;
  int tx_idle_pct, rx_idle_pct, rx_hold_req, sent_words;

  ttc_emergency_brake_top dut (
    .clk_i, .rst_ni, .push, .full, .in_word_i, .empty, .pop, .out_word_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Drain results, with random stalls and one long hold-off on request
  initial begin
    int hold;
    hold = 0;
    pop  = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) sb.check_result(out_word_o);
      if (rx_hold_req > 0) begin
        hold        = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold > 0) begin
        hold--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Guard against a hung block
  initial begin
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > LIMIT) begin
        $display("ttc_emergency_brake_top test failed");
        $finish;
      end
    end
  end

  task automatic send_word(teb_in_t w);
    if ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    push      <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (full);
    sb.note_input(w);
    sent_words++;
  endtask

  task automatic send_speed(logic signed [15:0] v);
    teb_in_t w;
    w.kind       = KIND_SPEED;
    w.speed_mm_s = v;
    w.range_mm   = 16'($urandom);
    w.last_beam  = 1'($urandom);
    send_word(w);
  endtask

  task automatic send_beam(logic [15:0] rng, logic last);
    teb_in_t w;
    w.kind       = KIND_BEAM;
    w.speed_mm_s = 16'($urandom);
    w.range_mm   = rng;
    w.last_beam  = last;
    send_word(w);
  endtask

  // Hold until every expected word is back and the back end has drained
  task automatic wait_idle();
    push <= 1'b0;
    while (sb.want_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [22:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_cfg();
    int sel;
    sel = $urandom_range(3);
    case (sel)
      0: write_cfg(CFG_ANGLE_START, 23'h400000);
      1: write_cfg(CFG_ANGLE_START, 23'h3FFFFF);
      default: write_cfg(CFG_ANGLE_START, 23'($urandom));
    endcase
    sel = $urandom_range(3);
    case (sel)
      0: write_cfg(CFG_ANGLE_STEP, 23'd0);
      1: write_cfg(CFG_ANGLE_STEP, 23'd65535);
      default: write_cfg(CFG_ANGLE_STEP, 23'($urandom_range(65535)));
    endcase
    sel = $urandom_range(4);
    case (sel)
      0: write_cfg(CFG_THRESHOLD, 23'd0);
      1: write_cfg(CFG_THRESHOLD, 23'd100000);
      2: write_cfg(CFG_THRESHOLD, 23'd131071);
      default: write_cfg(CFG_THRESHOLD, 23'($urandom_range(100, 5000)));
    endcase
    write_cfg(CFG_UNUSED, 23'($urandom));
  endtask

  task automatic random_speed();
    int sel;
    sel = $urandom_range(9);
    if (sel < 6)       send_speed(16'($urandom_range(1, 32767)));
    else if (sel < 8)  send_speed(16'($urandom));
    else if (sel == 8) send_speed(16'sh7FFF);
    else               send_speed(16'sh8000);
  endtask

  // Send random scans until the word budget is used
  task automatic random_phase(int budget, bit long_scan);
    int stop, len;
    stop = sent_words + budget;
    while (sent_words < stop) begin
      if ($urandom_range(3) != 0) random_speed();
      len = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      if (long_scan) begin
        len       = 2100;
        long_scan = 0;
      end
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(49) == 0) random_speed();
        send_beam($urandom_range(1) ? 16'($urandom_range(0, 4000)) : 16'($urandom),
                  i == len - 1);
      end
    end
  endtask

  initial begin
    sb          = new();
    rst_ni      = 1'b0;
    push        = 1'b0;
    in_word_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_ANGLE_START;
    cfg_data_i  = '0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold_req = 0;
    sent_words  = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero speed, extremes of range and speed, ignored fields
    send_beam(16'd65535, 1'b1);
    send_speed(16'sh7FFF);
    send_beam(16'd0, 1'b0);
    send_beam(16'd65535, 1'b1);
    send_speed(16'sh8000);
    send_beam(16'd500, 1'b0);
    send_beam(16'd300, 1'b1);
    send_speed(16'sd0);
    send_beam(16'd1000, 1'b1);
    wait_idle();
    // Threshold over the ceiling brakes even without any TTC
    write_cfg(CFG_THRESHOLD, 23'd131071);
    write_cfg(CFG_ANGLE_START, 23'd0);
    write_cfg(CFG_ANGLE_STEP, 23'd0);
    write_cfg(CFG_UNUSED, 23'h7FFFFF);
    send_speed(-16'sd1);
    send_beam(16'd40000, 1'b1);
    send_speed(16'sd1);
    send_beam(16'd40000, 1'b1);
    send_speed(16'sd32767);
    send_beam(16'd13000, 1'b0);
    send_beam(16'd1, 1'b1);
    wait_idle();

    // Random: receiver-heavy idling, then sender-heavy, then none
    tx_idle_pct = 32;
    rx_idle_pct = 84;
    random_cfg();
    random_phase(RAND_WORDS / 4, 0);
    wait_idle();
    tx_idle_pct = 84;
    rx_idle_pct = 32;
    random_cfg();
    random_phase(RAND_WORDS / 4, 0);
    wait_idle();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_cfg();
    write_cfg(CFG_ANGLE_STEP, 23'd4563);
    rx_hold_req = 4000;
    random_phase(RAND_WORDS / 2, 0);

    wait_idle();
    if (sb.errors == 0 && sb.want_q.size() == 0)
      $display("ttc_emergency_brake_top test passed");
    else
      $display("ttc_emergency_brake_top test failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/teb_pkg.sv
rtl/core/teb_front.sv
rtl/core/teb_queue.sv
rtl/core/teb_back.sv
rtl/core/ttc_emergency_brake_top.sv
dv/tb_ttc_emergency_brake_top.sv
